FILE: rtl/srecord_s1_s9_loader_assert.svh
// ----------------------------------------------------------------------------
// S-record loader assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef SRECORD_S1_S9_LOADER_ASSERT_SVH
`define SRECORD_S1_S9_LOADER_ASSERT_SVH

// Same-cycle implication
`define SREC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SREC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg
// Types, character codes and the hex digit decoder for the S-record loader.
// ----------------------------------------------------------------------------
package srec_pkg;

  // Target memory size; write addresses wrap within it
  localparam int unsigned MEMORY_SIZE = 65536;
  localparam logic [15:0] ADDR_MASK   = 16'(MEMORY_SIZE - 1);

  // ASCII codes
  localparam logic [7:0] CH_S   = 8'h53;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_UF  = 8'h46;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_LF  = 8'h66;

  // Record constants
  localparam logic [7:0] SUM_GOOD = 8'hFF;
  localparam logic [7:0] HDR_LEN  = 8'd3;  // two address bytes plus checksum

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_ADDR = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5,
    PH_DONE = 3'd6,
    PH_SKIP = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_S1    = 2'd0,
    KIND_S9    = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       line_end;
  } srec_in_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        record_done;
    logic        record_ok;
    logic [1:0]  record_kind;
    logic        start_valid;
    logic [15:0] start_address;
  } srec_out_t;

  // Input register contents handed to the parser
  typedef struct packed {
    logic     full;
    srec_in_t item;
  } srec_stage_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] val;
  } hex_t;

  // Hex digit decode; a non-hex character reads as zero and flags bad
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad = 1'b0;
    h.val = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      h.val = 4'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UF) begin
      h.val = 4'(c - CH_UA + 8'd10);
    end else if (c >= CH_LA && c <= CH_LF) begin
      h.val = 4'(c - CH_LA + 8'd10);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

FILE: rtl/srec_in_stage.sv
// ----------------------------------------------------------------------------
// srec_in_stage
// Input register: holds one accepted character until the parser takes it.
// ----------------------------------------------------------------------------
module srec_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  srec_pkg::srec_in_t in_item,
  input  logic              advance,
  output srec_pkg::srec_stage_t stage
);
  import srec_pkg::*;

  logic     full;
  srec_in_t item;

  // Free when empty or when the held character moves on this cycle
  assign in_ready = !full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

  assign stage.full = full;
  assign stage.item = item;

endmodule

FILE: rtl/srec_parse.sv
// ----------------------------------------------------------------------------
// srec_parse
// Record parser: per-character state update and result formation.
// ----------------------------------------------------------------------------
module srec_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  srec_pkg::srec_stage_t stage,
  input  logic                  keep_start_address,
  output logic                  res_valid,
  output srec_pkg::srec_out_t   res
);
  import srec_pkg::*;

  // Parser state
  phase_t      phase;
  logic [1:0]  digit_count;
  logic [15:0] acc;
  logic [15:0] cur_addr;
  logic [7:0]  bytes_rem;
  logic [7:0]  run_sum;
  kind_t       rec_type;
  logic        err;

  // Values after this character, before the line-end clear
  phase_t      phase_step;
  logic [1:0]  digit_step;
  logic [15:0] acc_step;
  logic [15:0] addr_step;
  logic [7:0]  rem_step;
  logic [7:0]  sum_step;
  kind_t       type_step;
  logic        err_step;
  logic        wr_step;
  logic [15:0] wr_addr;
  logic [7:0]  wr_data;

  phase_t      phase_next;
  logic [1:0]  digit_count_next;
  logic [15:0] acc_next;
  logic [15:0] cur_addr_next;
  logic [7:0]  bytes_rem_next;
  logic [7:0]  run_sum_next;
  kind_t       rec_type_next;
  logic        err_next;

  logic [7:0]  c;
  logic        line_end;

  assign c        = stage.item.text_char;
  assign line_end = stage.item.line_end;

  // Next state for one character
  always_comb begin
    hex_t        h;
    logic [15:0] acc_sh;
    logic [7:0]  b;
    logic [1:0]  last_digit;
    h          = hex_decode(c);
    acc_sh     = {acc[11:0], h.val};
    b          = acc_sh[7:0];
    last_digit = (phase == PH_ADDR) ? 2'd3 : 2'd1;

    phase_step = phase;
    digit_step = digit_count;
    acc_step   = acc;
    addr_step  = cur_addr;
    rem_step   = bytes_rem;
    sum_step   = run_sum;
    type_step  = rec_type;
    err_step   = err;
    wr_step    = 1'b0;
    wr_addr    = cur_addr & ADDR_MASK;
    wr_data    = b;

    unique case (phase)
      PH_LEAD: begin
        if (c != CH_S) err_step = 1'b1;
        phase_step = PH_TYPE;
      end
      PH_TYPE: begin
        digit_step = 2'd0;
        acc_step   = 16'd0;
        if (c == CH_1) begin
          type_step  = KIND_S1;
          phase_step = PH_LEN;
        end else if (c == CH_9) begin
          type_step  = KIND_S9;
          phase_step = PH_LEN;
        end else begin
          type_step  = KIND_OTHER;
          phase_step = PH_SKIP;
        end
      end
      PH_LEN, PH_ADDR, PH_DATA, PH_SUM: begin
        if (h.bad) err_step = 1'b1;
        if (digit_count < last_digit) begin
          acc_step   = acc_sh;
          digit_step = digit_count + 2'd1;
        end else begin
          acc_step   = 16'd0;
          digit_step = 2'd0;
          unique case (phase)
            PH_LEN: begin
              sum_step = run_sum + b;
              if (rec_type == KIND_S1) begin
                rem_step = (b >= HDR_LEN) ? b - HDR_LEN : 8'd0;
              end else begin
                rem_step = 8'd0;
                if (b != HDR_LEN) err_step = 1'b1;
              end
              phase_step = PH_ADDR;
            end
            PH_ADDR: begin
              addr_step  = acc_sh;
              sum_step   = run_sum + acc_sh[15:8] + b;
              phase_step = (rec_type == KIND_S1 && bytes_rem != 8'd0) ? PH_DATA : PH_SUM;
            end
            PH_DATA: begin
              sum_step  = run_sum + b;
              wr_step   = 1'b1;
              addr_step = cur_addr + 16'd1;
              rem_step  = bytes_rem - 8'd1;
              if (bytes_rem == 8'd1) phase_step = PH_SUM;
            end
            default: begin
              sum_step   = run_sum + b;
              phase_step = PH_DONE;
            end
          endcase
        end
      end
      PH_DONE, PH_SKIP: begin
      end
    endcase
  end

  // Result: status on line end, otherwise a data write if one completed
  always_comb begin
    logic addr_done;
    logic ok;
    addr_done = (type_step == KIND_S9) && (phase_step == PH_SUM || phase_step == PH_DONE);
    if (type_step == KIND_OTHER) begin
      ok = (phase_step == PH_SKIP) && !err_step;
    end else begin
      ok = (phase_step == PH_DONE) && !err_step && (sum_step == SUM_GOOD);
    end

    res       = '0;
    res_valid = 1'b0;
    if (line_end) begin
      res_valid         = 1'b1;
      res.record_done   = 1'b1;
      res.record_ok     = ok;
      res.record_kind   = type_step;
      res.start_valid   = addr_done && !keep_start_address;
      res.start_address = addr_done ? addr_step : 16'd0;
    end else if (wr_step) begin
      res_valid         = 1'b1;
      res.write_valid   = 1'b1;
      res.write_address = wr_addr;
      res.write_data    = wr_data;
    end
  end

  // Line end returns the record state to reset; the address carries over
  always_comb begin
    cur_addr_next = addr_step;
    if (line_end) begin
      phase_next       = PH_LEAD;
      digit_count_next = 2'd0;
      acc_next         = 16'd0;
      bytes_rem_next   = 8'd0;
      run_sum_next     = 8'd0;
      rec_type_next    = KIND_OTHER;
      err_next         = 1'b0;
    end else begin
      phase_next       = phase_step;
      digit_count_next = digit_step;
      acc_next         = acc_step;
      bytes_rem_next   = rem_step;
      run_sum_next     = sum_step;
      rec_type_next    = type_step;
      err_next         = err_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      digit_count <= 2'd0;
      acc         <= 16'd0;
      cur_addr    <= 16'd0;
      bytes_rem   <= 8'd0;
      run_sum     <= 8'd0;
      rec_type    <= KIND_OTHER;
      err         <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      acc         <= acc_next;
      cur_addr    <= cur_addr_next;
      bytes_rem   <= bytes_rem_next;
      run_sum     <= run_sum_next;
      rec_type    <= rec_type_next;
      err         <= err_next;
    end
  end

endmodule

FILE: rtl/srec_out_stage.sv
// ----------------------------------------------------------------------------
// srec_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module srec_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                res_valid,
  input  srec_pkg::srec_out_t res,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output srec_pkg::srec_out_t out_item
);
  import srec_pkg::*;

  logic      full;
  srec_out_t held;
  logic      load;

  // Room for a new result when empty or draining this cycle
  assign space = !full || out_ready;
  assign load  = advance && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign out_valid = full;
  assign out_item  = held;

endmodule

FILE: rtl/srecord_s1_s9_loader.sv
// ----------------------------------------------------------------------------
// srecord_s1_s9_loader
// A character's result goes from the input register through the parser into
// the result register, where the consumer takes it.
// Throughput: one character per cycle while the result register has room;
// the parser updates all record state in a single pass between the input
// register and the result register. Reset (rst, synchronous): parser back to
// "expect S", address 0, keep_start_address 0, both registers empty.
// ----------------------------------------------------------------------------
module srecord_s1_s9_loader (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srec_pkg::srec_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output srec_pkg::srec_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import srec_pkg::*;

  srec_stage_t stage;
  srec_out_t   res;
  logic        res_valid;
  logic        space;
  logic        advance;
  logic        keep_start_address;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_start_address <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      keep_start_address <= cfg_data;
    end
  end

  // A held character is parsed when the result register has room
  assign advance = stage.full && space;

  srec_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  srec_parse u_parse (
    .clk                (clk),
    .rst                (rst),
    .advance            (advance),
    .stage              (stage),
    .keep_start_address (keep_start_address),
    .res_valid          (res_valid),
    .res                (res)
  );

  srec_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/srec_checker.sv
// ----------------------------------------------------------------------------
// srec_checker
// Port-level checks on the loader's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "srecord_s1_s9_loader_assert.svh"

module srec_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input srec_pkg::srec_out_t out_item
);
  import srec_pkg::*;

  // A stalled result holds
  `SREC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

  // Each result is a write or a status, never both
  `SREC_ASSERT_IMP(a_one_kind, out_valid, out_item.write_valid != out_item.record_done, "result is not exactly one of write or status")

  // A start address is only applied from an S9 status
  `SREC_ASSERT_IMP(a_start_s9, out_valid && out_item.start_valid, out_item.record_done && out_item.record_kind == KIND_S9, "start applied outside an S9 status")

  // Write results carry no status
  `SREC_ASSERT_IMP(a_write_clean, out_valid && out_item.write_valid, !out_item.record_ok && !out_item.start_valid && out_item.start_address == 16'd0, "status bits set in a write")

endmodule

bind srecord_s1_s9_loader srec_checker u_srec_checker (.*);

FILE: dv/srecord_s1_s9_loader_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srecord_s1_s9_loader_test
// Streams S-record lines into the loader one character per transaction and
// checks every memory write and every end-of-line status against a parser
// kept in step with the block. Covers S1/S9 records, short and long data
// fields, address wrap, bad checksums, bad digits, truncation, junk lines and
// both settings of keep_start_address, with random stalls on both sides.
// ----------------------------------------------------------------------------
module srecord_s1_s9_loader_test;
  import srec_pkg::*;

  // Record flaws injected by the line builder
  localparam int FL_LOWER     = 1;
  localparam int FL_BAD_SUM   = 2;
  localparam int FL_BAD_LEAD  = 4;
  localparam int FL_BAD_DIGIT = 8;
  localparam int FL_TAIL      = 16;

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RAND_PHASES      = 4;
  localparam int RAND_CHARS       = 360;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  srec_in_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  srec_out_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  srecord_s1_s9_loader uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Character stream and predicted loader outputs
  logic [7:0] line_buf[$];
  srec_in_t   char_q[$];
  srec_out_t  load_results[$];
  srec_out_t  next_result;

  int  chars_queued = 0;
  int  chars_taken = 0;
  int  send_gap = 0;
  int  rx_gap = 0;
  int  hold_left = 0;
  bit  idle_on = 1'b1;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  int  fail_count = 0;
  int  n_writes = 0;
  int  n_status = 0;
  int  n_starts = 0;

  // Parser state mirrored in the testbench
  bit          keep_start = 1'b0;
  phase_t      p_phase;
  logic [1:0]  p_digits;
  logic [15:0] p_acc;
  logic [15:0] p_addr;
  logic [7:0]  p_left;
  logic [7:0]  p_sum;
  kind_t       p_kind;
  bit          p_bad;

  function automatic logic [3:0] hex_nibble(input logic [7:0] c, output bit bad);
    bad = 1'b0;
    if (c >= CH_0 && c <= CH_9) return 4'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return 4'(c - CH_UA + 8'd10);
    if (c >= CH_LA && c <= CH_LF) return 4'(c - CH_LA + 8'd10);
    bad = 1'b1;
    return 4'd0;
  endfunction

  function automatic void clear_record();
    p_phase  = PH_LEAD;
    p_digits = '0;
    p_acc    = '0;
    p_left   = '0;
    p_sum    = '0;
    p_kind   = KIND_OTHER;
    p_bad    = 1'b0;
  endfunction

  // Advance the parser by one character; returns 1 when the block owes a result
  function automatic bit parse_char(input srec_in_t item, output srec_out_t res);
    bit          bad;
    bit          wr;
    bit          addr_done;
    logic [3:0]  nib;
    logic [1:0]  last;
    logic [7:0]  b;
    logic [7:0]  c;
    res = '0;
    wr  = 1'b0;
    c   = item.text_char;
    case (p_phase)
      PH_LEAD: begin
        if (c != CH_S) p_bad = 1'b1;
        p_phase = PH_TYPE;
      end
      PH_TYPE: begin
        p_digits = '0;
        p_acc    = '0;
        if (c == CH_1) begin
          p_kind  = KIND_S1;
          p_phase = PH_LEN;
        end else if (c == CH_9) begin
          p_kind  = KIND_S9;
          p_phase = PH_LEN;
        end else begin
          p_kind  = KIND_OTHER;
          p_phase = PH_SKIP;
        end
      end
      PH_LEN, PH_ADDR, PH_DATA, PH_SUM: begin
        nib = hex_nibble(c, bad);
        if (bad) p_bad = 1'b1;
        p_acc = {p_acc[11:0], nib};
        last  = (p_phase == PH_ADDR) ? 2'd3 : 2'd1;
        if (p_digits < last) begin
          p_digits = p_digits + 2'd1;
        end else begin
          b = p_acc[7:0];
          case (p_phase)
            PH_LEN: begin
              p_sum = p_sum + b;
              if (p_kind == KIND_S1) begin
                p_left = (b >= HDR_LEN) ? b - HDR_LEN : 8'd0;
              end else begin
                p_left = 8'd0;
                if (b != HDR_LEN) p_bad = 1'b1;
              end
              p_phase = PH_ADDR;
            end
            PH_ADDR: begin
              p_addr  = p_acc;
              p_sum   = p_sum + p_acc[15:8] + b;
              p_phase = (p_kind == KIND_S1 && p_left != 0) ? PH_DATA : PH_SUM;
            end
            PH_DATA: begin
              p_sum = p_sum + b;
              wr    = 1'b1;
              res.write_address = p_addr & ADDR_MASK;
              res.write_data    = b;
              p_addr = p_addr + 16'd1;
              p_left = p_left - 8'd1;
              if (p_left == 0) p_phase = PH_SUM;
            end
            default: begin
              p_sum   = p_sum + b;
              p_phase = PH_DONE;
            end
          endcase
          p_digits = '0;
          p_acc    = '0;
        end
      end
      default: ;
    endcase

    // Line end: status replaces any write completed on this character
    if (item.line_end) begin
      res = '0;
      addr_done = (p_kind == KIND_S9) && (p_phase == PH_SUM || p_phase == PH_DONE);
      res.record_done = 1'b1;
      if (p_kind == KIND_OTHER)
        res.record_ok = (p_phase == PH_SKIP) && !p_bad;
      else
        res.record_ok = (p_phase == PH_DONE) && !p_bad && (p_sum == SUM_GOOD);
      res.record_kind   = p_kind;
      res.start_valid   = addr_done && !keep_start;
      res.start_address = addr_done ? p_addr : 16'd0;
      clear_record();
      return 1'b1;
    end
    if (wr) begin
      res.write_valid = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------- line building ----------------

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CH_0 + 8'(n);
    return (lower ? CH_LA : CH_UA) + 8'(n) - 8'd10;
  endfunction

  function automatic void put_byte(input logic [7:0] v, input bit lower);
    line_buf.push_back(hex_char(v[7:4], lower));
    line_buf.push_back(hex_char(v[3:0], lower));
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    bit bad;
    do begin
      c = 8'($urandom);
      void'(hex_nibble(c, bad));
    end while (!bad);
    return c;
  endfunction

  function automatic void commit_line();
    srec_in_t it;
    foreach (line_buf[i]) begin
      it.text_char = line_buf[i];
      it.line_end  = (i == line_buf.size() - 1);
      char_q.push_back(it);
    end
    chars_queued += line_buf.size();
    line_buf.delete();
  endfunction

  // One record line; cut < 0 truncates at a random point
  function automatic void queue_srec(input logic [7:0] type_ch, input logic [7:0] len,
                                     input logic [15:0] addr, input int ndata,
                                     input int flaws, input int cut);
    logic [7:0] sum;
    logic [7:0] d;
    logic [7:0] lead;
    bit lower;
    int pos;
    int n;
    lower = (flaws & FL_LOWER) != 0;
    line_buf.delete();
    if (flaws & FL_BAD_LEAD) begin
      do lead = 8'($urandom); while (lead == CH_S);
    end else begin
      lead = CH_S;
    end
    line_buf.push_back(lead);
    line_buf.push_back(type_ch);
    put_byte(len, lower);
    put_byte(addr[15:8], lower);
    put_byte(addr[7:0], lower);
    sum = len + addr[15:8] + addr[7:0];
    for (int i = 0; i < ndata; i++) begin
      d = 8'($urandom);
      sum = sum + d;
      put_byte(d, lower);
    end
    sum = ~sum;
    if (flaws & FL_BAD_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    put_byte(sum, lower);
    if (flaws & FL_BAD_DIGIT) begin
      pos = $urandom_range(2, line_buf.size() - 1);
      line_buf[pos] = junk_char();
    end
    n = (cut < 0) ? $urandom_range(1, line_buf.size() - 1) : cut;
    repeat (n) void'(line_buf.pop_back());
    if (flaws & FL_TAIL) repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom));
    commit_line();
  endfunction

  function automatic void queue_random_line();
    int pick;
    int n;
    int fl;
    int cut;
    logic [15:0] addr;
    logic [7:0]  ty;
    pick = $urandom_range(0, 99);
    addr = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 12))
                                       : 16'($urandom);
    fl   = $urandom_range(0, 1) ? FL_LOWER : 0;
    if ($urandom_range(0, 9) == 0) fl |= FL_TAIL;
    n    = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
    ty   = $urandom_range(0, 1) ? CH_1 : CH_9;
    cut  = 0;
    if (pick < 55) begin
      queue_srec(CH_1, 8'(n + 3), addr, n, fl, 0);
    end else if (pick < 65) begin
      queue_srec(CH_9, HDR_LEN, addr, 0, fl, 0);
    end else if (pick < 77) begin
      // well-formed shape with one flaw
      case ($urandom_range(0, 3))
        0:       fl |= FL_BAD_SUM;
        1:       fl |= FL_BAD_LEAD;
        2:       fl |= FL_BAD_DIGIT;
        default: cut = -1;
      endcase
      queue_srec(ty, (ty == CH_1) ? 8'(n + 3) : HDR_LEN, addr, (ty == CH_1) ? n : 0, fl, cut);
    end else if (pick < 85) begin
      // length field disagrees with the data that follows
      queue_srec(ty, 8'($urandom_range(0, 16)), addr, $urandom_range(0, 10), fl, 0);
    end else if (pick < 92) begin
      // unrecognized record type
      do ty = 8'($urandom); while (ty == CH_1 || ty == CH_9);
      if ($urandom_range(0, 3) == 0) fl |= FL_BAD_LEAD;
      queue_srec(ty, 8'(n + 3), addr, n, fl, 0);
    end else begin
      // raw noise
      line_buf.delete();
      repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom));
      if ($urandom_range(0, 1)) line_buf[0] = CH_S;
      commit_line();
    end
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // transaction completed at this edge: predict its outputs
      if (in_valid && in_ready) begin
        if (parse_char(in_item, next_result)) load_results.push_back(next_result);
        chars_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          in_item  <= char_q.pop_front();
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver back-pressure ----------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap = 0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rx_gap = $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------- monitor ----------------
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 40)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  srec_out_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (load_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $display("%0t ns: unexpected transaction, expected none, actual %h", $time, out_item);
      end else begin
        want = load_results.pop_front();
        if (want.write_valid) n_writes++;
        else n_status++;
        if (want.start_valid) n_starts++;
        check_field("write_valid", 16'(want.write_valid), 16'(out_item.write_valid));
        check_field("write_address", want.write_address, out_item.write_address);
        check_field("write_data", 16'(want.write_data), 16'(out_item.write_data));
        check_field("record_done", 16'(want.record_done), 16'(out_item.record_done));
        check_field("record_ok", 16'(want.record_ok), 16'(out_item.record_ok));
        check_field("record_kind", 16'(want.record_kind), 16'(out_item.record_kind));
        check_field("start_valid", 16'(want.start_valid), 16'(out_item.start_valid));
        check_field("start_address", want.start_address, out_item.start_address);
      end
    end
  end

  // ---------------- sequencing ----------------

  // Sender holds off until every predicted output has arrived
  task automatic wait_idle();
    do @(posedge clk); while (chars_taken != chars_queued || load_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep_start(input bit v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    keep_start = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int target;
    clear_record();
    p_addr = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_keep_start(1'b0);

    // Directed records, start address applied
    queue_srec(CH_1, 8'd7, 16'hFFFE, 4, 0, 0);              // address wraps
    queue_srec(CH_1, HDR_LEN, 16'h0000, 0, 0, 0);           // no data bytes
    queue_srec(CH_1, 8'd0, 16'h1234, 0, 0, 0);              // length below 3
    queue_srec(CH_1, 8'd2, 16'hFFFF, 0, FL_LOWER, 0);
    queue_srec(CH_9, HDR_LEN, 16'hABCD, 0, 0, 0);
    queue_srec(CH_9, 8'd4, 16'h5A5A, 0, 0, 0);              // S9 with wrong length
    queue_srec(CH_1, 8'd5, 16'h2000, 2, FL_BAD_SUM, 0);
    queue_srec(CH_1, 8'd5, 16'h2100, 2, FL_BAD_LEAD, 0);
    queue_srec(CH_1, 8'd6, 16'h2200, 3, FL_BAD_DIGIT, 0);
    queue_srec(CH_1, 8'd6, 16'hBEEF, 3, FL_LOWER, 0);
    queue_srec(CH_1, 8'd6, 16'h3000, 3, 0, 2);              // last data byte on line end
    queue_srec(CH_1, 8'd8, 16'h3100, 5, 0, -1);             // cut short
    queue_srec(CH_1, 8'd4, 16'h3200, 1, FL_TAIL, 0);        // junk after checksum
    queue_srec(8'h35, 8'd4, 16'h4000, 1, 0, 0);             // unknown type digit
    queue_srec(8'h30, 8'd4, 16'h4000, 1, FL_BAD_LEAD, 0);
    line_buf.push_back(CH_S);                               // ends before type digit
    commit_line();
    line_buf.push_back(8'hFF);
    commit_line();
    line_buf.push_back(CH_S);                               // ends on type digit
    line_buf.push_back(CH_1);
    commit_line();
    queue_srec(CH_9, HDR_LEN, 16'h8001, 0, 0, 4);           // S9 cut inside address
    queue_srec(CH_9, HDR_LEN, 16'h0000, 0, FL_BAD_SUM, 0);
    queue_srec(CH_9, HDR_LEN, 16'hFFFF, 0, FL_TAIL, 2);     // S9 without checksum
    wait_idle();

    // Start address reported but kept
    write_keep_start(1'b1);
    queue_srec(CH_9, HDR_LEN, 16'h1357, 0, 0, 0);
    queue_srec(CH_9, HDR_LEN, 16'hFFFF, 0, FL_BAD_SUM, 0);
    queue_srec(CH_9, HDR_LEN, 16'h2468, 0, 0, 2);
    queue_srec(CH_1, 8'd5, 16'h0100, 2, 0, 0);
    wait_idle();

    // Long records while the receiver stalls
    write_keep_start(1'b0);
    long_hold_req = 1'b1;
    queue_srec(CH_1, 8'd67, 16'hFFE0, 64, 0, 0);
    queue_srec(CH_1, 8'd35, 16'h0000, 32, FL_LOWER, 0);
    queue_srec(CH_9, HDR_LEN, 16'h0000, 0, 0, 0);
    wait_idle();

    // Random records; no idling in the last phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_keep_start(ph[0] == 1'b0);
      if (ph == RAND_PHASES - 1) idle_on = 1'b0;
      target = chars_queued + RAND_CHARS / RAND_PHASES;
      while (chars_queued < target) queue_random_line();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (load_results.size() != 0) fail_count++;
    $display("Sent %0d characters; checked %0d memory writes and %0d record statuses.",
             chars_taken, n_writes, n_status);
    $display("%0d start addresses applied; keep_start_address exercised at 0 and 1.",
             n_starts);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/srec_pkg.sv
rtl/srec_in_stage.sv
rtl/srec_parse.sv
rtl/srec_out_stage.sv
rtl/srecord_s1_s9_loader.sv
rtl/srec_checker.sv
dv/srecord_s1_s9_loader_test.sv
